// ===== rtl/core/iidl_pkg.sv =====
// Shared types and codes for the indexed insert/delete list.
package iidl_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  localparam logic [1:0] STATUS_ENTRY   = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] entry_value;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic       ins;
    logic       del;
    logic [7:0] pos;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/iidl_cell.sv =====
// One list slot: holds a value and shifts it with its neighbors on insert or delete.
module iidl_cell
  import iidl_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic signed [31:0] new_value,
  input  logic signed [31:0] left_value,
  input  logic signed [31:0] right_value,
  output logic signed [31:0] value
);

  localparam logic [7:0] IDX_L = 8'(IDX);

  logic signed [31:0] value_r;
  logic signed [31:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.ins) begin
      if (ctrl.pos == IDX_L) begin
        value_nxt = new_value;
      end else if (ctrl.pos < IDX_L) begin
        value_nxt = left_value;
      end
    end else if (ctrl.del) begin
      if (ctrl.pos <= IDX_L) begin
        value_nxt = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

// ===== rtl/core/indexed_insert_delete_list_top.sv =====
// Top level of the indexed insert/delete list built as a chain of shifting cells.
//
// Usage: items enter on in_valid/in_stall/in_item. An insert places a value at a
// position from 0 to the current count, a delete removes the entry at a position
// below the count; both complete in the cycle they are accepted, so such items
// are taken one per cycle. A bad position or an insert into a full list sets a
// sticky error, after which inserts and deletes are dropped. Mode three is dropped.
// A finish item reports on out_valid/out_stall/out_item: one invalid-sequence
// result if the error is set, one empty result for an empty list, otherwise every
// entry in order with last on the final one. Then the list and error are cleared.
// A dump shifts the whole cell chain toward the head and sends one entry per
// cycle while the output register is free, from cell zero into that register; the
// input stays stalled until the last entry or the status result is sent.
// The first result is sent from the dump or status state that the finish enters.
// A stalled result stays in the output register; nothing is dropped.
// Reset (rst_n low, synchronous) empties the list, clears the error and the
// output valid; the cells themselves hold no reset value.
module indexed_insert_delete_list_top
  import iidl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DUMP   = 3'b010,
    ST_STATUS = 3'b100
  } state_t;

  state_t     state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic       err_r, err_nxt;
  logic [1:0] status_r, status_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;

  logic       in_acc;
  logic       out_free;
  logic       dump_emit;
  logic [8:0] pos9;
  logic [8:0] cnt9;
  cell_ctrl_t ctrl;
  logic signed [31:0] cell_val [CAPACITY];

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign dump_emit = (state_r == ST_DUMP) && out_free;
  assign pos9      = {1'b0, in_item.position};
  assign cnt9      = 9'(count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    err_nxt       = err_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    ctrl          = '0;
    ctrl.pos      = in_item.position;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_item.mode)
            MODE_INSERT: begin
              if (!err_r) begin
                if (pos9 > cnt9 || count_r >= CW'(CAPACITY)) begin
                  err_nxt = 1'b1;
                end else begin
                  ctrl.ins  = 1'b1;
                  count_nxt = count_r + CW'(1);
                end
              end
            end
            MODE_DELETE: begin
              if (!err_r) begin
                if (pos9 >= cnt9) begin
                  err_nxt = 1'b1;
                end else begin
                  ctrl.del  = 1'b1;
                  count_nxt = count_r - CW'(1);
                end
              end
            end
            MODE_FINISH: begin
              err_nxt = 1'b0;
              if (err_r) begin
                status_nxt = STATUS_INVALID;
                count_nxt  = '0;
                state_nxt  = ST_STATUS;
              end else if (count_r == '0) begin
                status_nxt = STATUS_EMPTY;
                state_nxt  = ST_STATUS;
              end else begin
                state_nxt = ST_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (dump_emit) begin
          // Head entry leaves; the chain shifts one place toward the head.
          ctrl.del                 = 1'b1;
          ctrl.pos                 = '0;
          out_valid_nxt            = 1'b1;
          out_item_nxt.entry_value = cell_val[0];
          out_item_nxt.status      = STATUS_ENTRY;
          out_item_nxt.last        = (count_r == CW'(1));
          count_nxt                = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.entry_value = '0;
          out_item_nxt.status      = status_r;
          out_item_nxt.last        = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    out_item_r <= out_item_nxt;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_v;
    logic signed [31:0] right_v;
    if (i == 0) begin : g_head
      assign left_v = in_item.value;
    end else begin : g_body
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = cell_val[i];
    end else begin : g_inner
      assign right_v = cell_val[i+1];
    end
    iidl_cell #(
      .IDX(i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_value  (in_item.value),
      .left_value (left_v),
      .right_value(right_v),
      .value      (cell_val[i])
    );
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |-> (count_r != '0))
    else $error("dump running on an empty list");

  a_finish_clears_err: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_item.mode == MODE_FINISH) |=> !err_r)
    else $error("error flag survived a finish");

  a_last_ends_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (dump_emit && count_r == CW'(1)) |=> (state_r == ST_IDLE && out_valid_r
      && out_item_r.last))
    else $error("final dump entry did not end the dump");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STATUS && out_free) |=> (out_valid_r && out_item_r.last
      && out_item_r.entry_value == '0))
    else $error("status result malformed");

endmodule
